// ----- sv/hrhp_pkg.sv -----
// Shared types, constants and character tables for the HTTP response header parser.
package hrhp_pkg;

  localparam int LINE_CHARS_DEF = 31;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  localparam int STATUS_PREFIX_LEN = 7;
  localparam int STATUS_NUM_POS    = 9;
  localparam int LENGTH_PREFIX_LEN = 16;
  localparam int LENGTH_NUM_POS    = 16;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [9:0]  STATUS_MAX = 10'd999;
  localparam logic [31:0] MAG_CAP    = 32'h8000_0000;
  localparam logic [31:0] LENGTH_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] LENGTH_NONE = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    PH_BLANKS = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [9:0]         status_code;
    logic signed [31:0] content_length;
    logic               timed_out;
  } result_t;

  // Characters of "HTTP/1." by position.
  function automatic logic [7:0] status_prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = "H";
      3'd1:    ch = "T";
      3'd2:    ch = "T";
      3'd3:    ch = "P";
      3'd4:    ch = "/";
      3'd5:    ch = "1";
      3'd6:    ch = ".";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Characters of "Content-Length: " by position.
  function automatic logic [7:0] length_prefix_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = "C";
      4'd1:    ch = "o";
      4'd2:    ch = "n";
      4'd3:    ch = "t";
      4'd4:    ch = "e";
      4'd5:    ch = "n";
      4'd6:    ch = "t";
      4'd7:    ch = "-";
      4'd8:    ch = "L";
      4'd9:    ch = "e";
      4'd10:   ch = "n";
      4'd11:   ch = "g";
      4'd12:   ch = "t";
      4'd13:   ch = "h";
      4'd14:   ch = ":";
      default: ch = " ";
    endcase
    return ch;
  endfunction

endpackage

// ----- sv/hrhp_parser.sv -----
// Per-transaction parse state: line matching, number accumulation and the timeout countdown.
module hrhp_parser import hrhp_pkg::*; #(
  parameter int LINE_CHARS = LINE_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  output logic        produce,
  output result_t     result
);

  localparam int LEN_W = $clog2(LINE_CHARS + 1);

  logic [15:0]      timeout_ticks;
  logic [LEN_W-1:0] line_length, line_length_next;
  logic             status_match, status_match_next;
  logic             length_match, length_match_next;
  phase_t           number_phase, number_phase_next;
  logic             number_negative, number_negative_next;
  logic [31:0]      number_value, number_value_next;
  logic [9:0]       status_value, status_value_next;
  logic [31:0]      length_value, length_value_next;
  logic [15:0]      countdown, countdown_next;
  logic             swallow_next, swallow_next_next;

  logic             is_digit, is_blank, is_sign;
  logic [35:0]      acc;
  logic [31:0]      acc_sat;
  logic             sp_keep, lp_keep, num_active;
  logic [LEN_W-1:0] num_start;
  logic [9:0]       status_end;
  logic [31:0]      length_end;
  logic [15:0]      cd_dec;
  logic             start_hdr, clear_ln;

  always_comb begin
    is_digit = data_byte inside {["0":"9"]};
    is_blank = data_byte inside {8'h20, 8'h09, 8'h0B, 8'h0C};
    is_sign  = data_byte inside {"+", "-"};
  end

  // Times ten as two shifts, plus the digit, capped at the magnitude limit.
  assign acc = {1'b0, number_value, 3'b000} + {3'b000, number_value, 1'b0}
             + {32'd0, data_byte[3:0] - CH_ZERO[3:0]};
  assign acc_sat = (acc > {4'd0, MAG_CAP}) ? MAG_CAP : acc[31:0];

  assign sp_keep = status_match &&
                   !(line_length < LEN_W'(STATUS_PREFIX_LEN) &&
                     data_byte != status_prefix_char(line_length[2:0]));
  assign lp_keep = length_match &&
                   !(line_length < LEN_W'(LENGTH_PREFIX_LEN) &&
                     data_byte != length_prefix_char(line_length[3:0]));
  assign num_start  = sp_keep ? LEN_W'(STATUS_NUM_POS) : LEN_W'(LENGTH_NUM_POS);
  assign num_active = (sp_keep || lp_keep) && (line_length >= num_start);

  assign status_end = number_negative ? 10'd0 :
                      (number_value > {22'd0, STATUS_MAX}) ? STATUS_MAX : number_value[9:0];
  assign length_end = number_negative ? ((number_value == 32'd0) ? 32'd0 : LENGTH_NONE) :
                      (number_value > LENGTH_MAX) ? LENGTH_MAX : number_value;

  assign cd_dec = (countdown != 16'd0) ? countdown - 16'd1 : 16'd0;

  always_comb begin
    line_length_next     = line_length;
    status_match_next    = status_match;
    length_match_next    = length_match;
    number_phase_next    = number_phase;
    number_negative_next = number_negative;
    number_value_next    = number_value;
    status_value_next    = status_value;
    length_value_next    = length_value;
    countdown_next       = countdown;
    swallow_next_next    = swallow_next;
    start_hdr            = 1'b0;
    clear_ln             = 1'b0;
    produce              = 1'b0;
    result.status_code    = status_value;
    result.content_length = length_value;
    result.timed_out      = 1'b0;

    if (accept) begin
      if (kind) begin
        if (cd_dec == 16'd0) begin
          produce               = 1'b1;
          result.status_code    = 10'd0;
          result.content_length = LENGTH_NONE;
          result.timed_out      = 1'b1;
          swallow_next_next     = 1'b0;
          start_hdr             = 1'b1;
        end else begin
          countdown_next = cd_dec;
        end
      end else if (swallow_next) begin
        swallow_next_next = 1'b0;
      end else if (data_byte == CH_LF) begin
        // Line feeds carry no information here.
      end else if (data_byte == CH_CR) begin
        if (line_length == '0) begin
          // Blank line closes the header; the byte after it is dropped.
          produce           = 1'b1;
          start_hdr         = 1'b1;
          swallow_next_next = 1'b1;
        end else begin
          if (status_match && line_length >= LEN_W'(STATUS_PREFIX_LEN)) begin
            status_value_next = status_end;
          end else if (length_match && line_length >= LEN_W'(LENGTH_PREFIX_LEN)) begin
            length_value_next = length_end;
          end
          clear_ln = 1'b1;
        end
      end else if (line_length < LEN_W'(LINE_CHARS)) begin
        status_match_next = sp_keep;
        length_match_next = lp_keep;
        line_length_next  = line_length + LEN_W'(1);
        if (num_active) begin
          case (number_phase)
            PH_BLANKS: begin
              if (is_blank) begin
                number_phase_next = PH_BLANKS;
              end else if (is_sign) begin
                number_negative_next = (data_byte == CH_MINUS);
                number_phase_next    = PH_DIGITS;
              end else if (is_digit) begin
                number_phase_next = PH_DIGITS;
                number_value_next = acc_sat;
              end else begin
                number_phase_next = PH_DONE;
              end
            end
            PH_DIGITS: begin
              if (is_digit) begin
                number_value_next = acc_sat;
              end else begin
                number_phase_next = PH_DONE;
              end
            end
            PH_DONE: begin
              number_phase_next = PH_DONE;
            end
            default: begin
              number_phase_next = PH_DONE;
            end
          endcase
        end
      end
    end

    if (start_hdr || clear_ln) begin
      line_length_next     = '0;
      status_match_next    = 1'b1;
      length_match_next    = 1'b1;
      number_phase_next    = PH_BLANKS;
      number_negative_next = 1'b0;
      number_value_next    = 32'd0;
    end
    if (start_hdr) begin
      status_value_next = 10'd0;
      length_value_next = LENGTH_NONE;
      countdown_next    = timeout_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks   <= TIMEOUT_RESET;
      line_length     <= '0;
      status_match    <= 1'b1;
      length_match    <= 1'b1;
      number_phase    <= PH_BLANKS;
      number_negative <= 1'b0;
      number_value    <= 32'd0;
      status_value    <= 10'd0;
      length_value    <= LENGTH_NONE;
      countdown       <= TIMEOUT_RESET;
      swallow_next    <= 1'b0;
    end else begin
      if (cfg_write) begin
        timeout_ticks <= cfg_data;
      end
      line_length     <= line_length_next;
      status_match    <= status_match_next;
      length_match    <= length_match_next;
      number_phase    <= number_phase_next;
      number_negative <= number_negative_next;
      number_value    <= number_value_next;
      status_value    <= status_value_next;
      length_value    <= length_value_next;
      countdown       <= countdown_next;
      swallow_next    <= swallow_next_next;
    end
  end

endmodule

// ----- sv/http_response_header_parser.sv -----
// Top level of the HTTP response header parser with output register and skid stage.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-----------------------------------------
//   input    | in_valid / in_ready     | kind, data_byte
//   output   | out_valid / out_ready   | status_code, content_length, timed_out
//   config   | cfg_write (no wait)     | cfg_data (timeout_ticks)
//
// Each input transaction is consumed at its accepting edge: the parse state updates
// at that edge and any result is registered on that same edge, in the output
// register or, while that one still waits, in the skid register.
// Throughput is one transaction per cycle while in_ready is high. A skid register
// behind the output register lets the input keep moving while a result waits;
// in_ready drops only when both hold results. Reset is synchronous and active
// high; it restores the timeout to 1000 ticks and starts a fresh header with
// empty output buffers.
module http_response_header_parser import hrhp_pkg::*; #(
  parameter int LINE_CHARS = LINE_CHARS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [7:0]         data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         status_code,
  output logic signed [31:0] content_length,
  output logic               timed_out,
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data
);

  logic    accept;
  logic    produce;
  result_t new_result;
  result_t out_reg;
  result_t skid_reg;
  logic    skid_valid;

  // The skid register is empty whenever new input may come in, so a result
  // always has somewhere to go.
  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;

  hrhp_parser #(
    .LINE_CHARS(LINE_CHARS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .kind      (kind),
    .data_byte (data_byte),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .produce   (produce),
    .result    (new_result)
  );

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid) begin
        out_valid <= produce;
      end else if (out_ready) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          out_valid <= produce;
        end
      end else if (produce) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || (out_ready && !skid_valid)) begin
      out_reg <= new_result;
    end else if (out_ready && skid_valid) begin
      out_reg <= skid_reg;
    end
    if (out_valid && !out_ready && produce) begin
      skid_reg <= new_result;
    end
  end

  assign status_code    = out_reg.status_code;
  assign content_length = out_reg.content_length;
  assign timed_out      = out_reg.timed_out;

endmodule

// ----- sv/hrhp_checker.sv -----
// Port-level assertions for the HTTP response header parser and their bind.
module hrhp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [9:0]         status_code,
  input logic signed [31:0] content_length,
  input logic               timed_out
);

  // No result may appear in the cycle after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // Input back-pressure only happens while a result is waiting.
  assert property (@(posedge clk) disable iff (rst) !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // A timeout result always carries the empty status and length.
  assert property (@(posedge clk) disable iff (rst)
      out_valid && timed_out |-> status_code == 10'd0 && content_length == -32'sd1)
    else $error("timeout result with stale header values");

  // Status codes are saturated.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> status_code <= 10'd999)
    else $error("status code above saturation limit");

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> out_valid && $stable(status_code) &&
      $stable(content_length) && $stable(timed_out))
    else $error("stalled result changed");

endmodule

bind http_response_header_parser hrhp_checker u_hrhp_checker (.*);
